[hw/rtl/rgb_box_downsample_2x2_unit_defines.svh]
// Assertion macros shared by the checker of the 2x2 box downsampler.
// No dependencies; the including file supplies clk and arst_n in scope.
`ifndef RGB_BOX_DOWNSAMPLE_2X2_UNIT_DEFINES_SVH
`define RGB_BOX_DOWNSAMPLE_2X2_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define RBD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbd checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define RBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbd checker: next-cycle property failed");

`endif

[hw/rtl/rbd_pkg.sv]
// Shared types, constants and helper functions of the 2x2 box downsampler.
// No dependencies.
`timescale 1ns / 1ps

package rbd_pkg;

	localparam int MAX_WIDTH_LOG2 = 12;
	localparam int CNT_W          = MAX_WIDTH_LOG2;
	localparam int IDX_W          = MAX_WIDTH_LOG2 - 1;
	localparam int LINE_DEPTH     = 1 << IDX_W;
	localparam int CH_W           = 8;
	localparam int CH_SUM_W       = CH_W + 1;
	localparam int PAIR_W         = 3 * CH_SUM_W;
	localparam int CFG_W          = 4;
	localparam int CFG_IDX_W      = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] pixel_red;
		logic [CH_W-1:0] pixel_green;
		logic [CH_W-1:0] pixel_blue;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] avg_red;
		logic [CH_W-1:0] avg_green;
		logic [CH_W-1:0] avg_blue;
		logic            image_done;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] width_log2;
		logic [CFG_W-1:0] height_log2;
	} cfg_t;

	// Front stage to merge stage: one pending output pixel.
	typedef struct packed {
		logic              valid;
		logic [PAIR_W-1:0] pair;
		logic              done;
	} front_s1_t;

	// Saturates a log2 size at the largest supported value and returns the
	// matching counter mask.
	function automatic logic [CNT_W-1:0] log2_mask(input logic [CFG_W-1:0] l);
		logic [CFG_W-1:0] c;
		logic [CNT_W:0]   m;
		c = (l > CFG_W'(MAX_WIDTH_LOG2)) ? CFG_W'(MAX_WIDTH_LOG2) : l;
		m = ((CNT_W+1)'(1) << c) - (CNT_W+1)'(1);
		return m[CNT_W-1:0];
	endfunction

	// Packs an input pixel into three 9-bit channel fields, red lowest.
	function automatic logic [PAIR_W-1:0] pack_pixel(input pixel_t p);
		return {1'b0, p.pixel_blue, 1'b0, p.pixel_green, 1'b0, p.pixel_red};
	endfunction

endpackage

[hw/rtl/rbd_line_ram.sv]
// Generic simple dual-port RAM with a registered read port, used as line buffer.
// No dependencies.
`timescale 1ns / 1ps

module rbd_line_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 27
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/rbd_front.sv]
// Raster counters, pair-sum register and line-buffer access of the downsampler.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rbd_pkg::cfg_t                   cfg,
	input  logic                            in_valid,
	input  rbd_pkg::pixel_t                 in_data,
	output logic                            in_stall,
	input  logic                            take,
	output rbd_pkg::front_s1_t              s1,
	output logic                            ram_we,
	output logic                            ram_re,
	output logic [rbd_pkg::IDX_W-1:0]       ram_addr,
	output logic [rbd_pkg::PAIR_W-1:0]      ram_wdata
);

	logic [rbd_pkg::CNT_W-1:0]  column_q;
	logic [rbd_pkg::CNT_W-1:0]  row_q;
	logic [rbd_pkg::PAIR_W-1:0] pair_q;

	logic                       valid_s1;
	logic [rbd_pkg::PAIR_W-1:0] pair_s1;
	logic                       done_s1;

	logic [rbd_pkg::CNT_W-1:0]  wmask;
	logic [rbd_pkg::CNT_W-1:0]  hmask;
	logic [rbd_pkg::CNT_W-1:0]  col;
	logic [rbd_pkg::CNT_W-1:0]  row;
	logic [rbd_pkg::PAIR_W-1:0] pair_next;
	logic                       accept;
	logic                       odd_col;
	logic                       odd_row;
	logic                       last_col;

	assign wmask    = rbd_pkg::log2_mask(cfg.width_log2);
	assign hmask    = rbd_pkg::log2_mask(cfg.height_log2);
	assign col      = column_q & wmask;
	assign row      = row_q & hmask;
	assign odd_col  = col[0];
	assign odd_row  = row[0];
	assign last_col = (col == wmask);

	// Only a full result slot that cannot move on holds the input back.
	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;

	// Channel sums stay below 512 per field, so the packed add never carries
	// across fields in the bits that are used.
	assign pair_next = odd_col ? (pair_q + rbd_pkg::pack_pixel(in_data))
	                           : rbd_pkg::pack_pixel(in_data);

	assign ram_addr  = col[rbd_pkg::CNT_W-1:1];
	assign ram_wdata = pair_next;
	assign ram_we    = accept && odd_col && !odd_row;
	assign ram_re    = accept && odd_col && odd_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			pair_q   <= '0;
		end else if (accept) begin
			pair_q <= pair_next;
			if (last_col) begin
				column_q <= '0;
				row_q    <= (row + rbd_pkg::CNT_W'(1)) & hmask;
			end else begin
				column_q <= col + rbd_pkg::CNT_W'(1);
				row_q    <= row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= ram_re;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			pair_s1 <= pair_next;
			done_s1 <= last_col && (row == hmask);
		end
	end

	assign s1.valid = valid_s1;
	assign s1.pair  = pair_s1;
	assign s1.done  = done_s1;

endmodule

[hw/rtl/rbd_merge.sv]
// Adds the stored and current pair sums, averages and holds the output register.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rbd_pkg::front_s1_t         s1,
	input  logic [rbd_pkg::PAIR_W-1:0] line_data,
	output logic                       take,
	output logic                       out_valid,
	input  logic                       out_stall,
	output rbd_pkg::result_t           out_data
);

	localparam int SW = rbd_pkg::CH_SUM_W;

	logic             out_valid_q;
	rbd_pkg::result_t out_q;
	logic [SW:0]      sum_r;
	logic [SW:0]      sum_g;
	logic [SW:0]      sum_b;

	assign sum_r = {1'b0, line_data[SW-1:0]}      + {1'b0, s1.pair[SW-1:0]};
	assign sum_g = {1'b0, line_data[2*SW-1:SW]}   + {1'b0, s1.pair[2*SW-1:SW]};
	assign sum_b = {1'b0, line_data[3*SW-1:2*SW]} + {1'b0, s1.pair[3*SW-1:2*SW]};

	assign take = s1.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Dropping the two low bits of the four-sample sum truncates the mean.
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.avg_red    <= sum_r[rbd_pkg::CH_W+1:2];
			out_q.avg_green  <= sum_g[rbd_pkg::CH_W+1:2];
			out_q.avg_blue   <= sum_b[rbd_pkg::CH_W+1:2];
			out_q.image_done <= s1.done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/rgb_box_downsample_2x2_unit.sv]
// Top level of the 2x2 box-filter downsampler for RGB raster streams.
// Depends on rbd_pkg, rbd_line_ram, rbd_front and rbd_merge.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// -------   ----------------------    --------------------------------------
// in        in_valid / in_stall       in_data  (pixel_red, green, blue)
// out       out_valid / out_stall     out_data (avg_red, green, blue, done)
// cfg       cfg_we                    cfg_index, cfg_data (no read-back)
//
// One pixel is taken in every cycle while in_stall is low; the line buffer read and
// the pair-sum add never hold the flow, so the rate is one transfer per clock unless in_stall is high.
// An output pixel is offered once the odd-column, odd-row pixel that completes
// its 2x2 block has passed the front-stage result slot and the output register.
// Reset clears the raster counters, the pair sum, the pipeline valid bits and
// sets both size registers to 8; the line buffer is not cleared and needs no
// clearing pass, since each entry is written on an even row before it is read.
// in_stall rises only when a finished result waits in the output register
// under out_stall and a second one is already queued behind it.

module rgb_box_downsample_2x2_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rbd_pkg::pixel_t                in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output rbd_pkg::result_t               out_data,
	input  logic                           cfg_we,
	input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbd_pkg::CFG_W-1:0]      cfg_data
);

	rbd_pkg::cfg_t              cfg_q;
	rbd_pkg::front_s1_t         s1;
	logic                       take;
	logic                       ram_we;
	logic                       ram_re;
	logic [rbd_pkg::IDX_W-1:0]  ram_addr;
	logic [rbd_pkg::PAIR_W-1:0] ram_wdata;
	logic [rbd_pkg::PAIR_W-1:0] ram_rdata;

	// Size registers. Values above the supported maximum are saturated where
	// they are used, not here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_log2  <= rbd_pkg::CFG_W'(8);
			cfg_q.height_log2 <= rbd_pkg::CFG_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbd_pkg::REG_WIDTH_LOG2: begin
					cfg_q.width_log2 <= cfg_data;
				end
				rbd_pkg::REG_HEIGHT_LOG2: begin
					cfg_q.height_log2 <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The front stage counts the raster, builds column-pair sums and stores
	// them on even rows; on odd rows it reads the stored sum back.
	rbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.take      (take),
		.s1        (s1),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata)
	);

	// Line buffer: one entry per column pair of the widest image.
	rbd_line_ram #(
		.DEPTH (rbd_pkg::LINE_DEPTH),
		.WIDTH (rbd_pkg::PAIR_W)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// The merge stage combines the stored and current pair sums into the
	// averaged output pixel and holds it until the transfer completes.
	rbd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.line_data (ram_rdata),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[hw/rtl/rbd_checker.sv]
// Port-level checker of the 2x2 box downsampler, bound to the top level.
// Depends on rbd_pkg and rgb_box_downsample_2x2_unit_defines.svh.
`timescale 1ns / 1ps
`include "rgb_box_downsample_2x2_unit_defines.svh"

module rbd_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_stall,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  rbd_pkg::result_t               out_data
);

	// A stalled result stays offered and unchanged.
	`RBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`RBD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))

	// The input is held back only behind a result that cannot leave.
	`RBD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

	// Nothing is offered right after reset is released.
	`RBD_ASSERT_NOW(a_reset_empty, $rose(arst_n), !out_valid && !in_stall)

endmodule

bind rgb_box_downsample_2x2_unit rbd_checker u_rbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
